FILE: design/ecd_pkg.sv
// Package for the elevator call dispatcher: field widths, reset values and
// default parameter values. No dependencies.
package ecd_pkg;

  localparam int FLOOR_W       = 8;   // floor number width
  localparam int CAR_NUM_W     = 3;   // width of a car number in a result
  localparam int CARS_DEF      = 3;   // default number of cars
  localparam int TOP_FLOOR_RST = 9;   // reset value of the top floor register
  localparam int PARK_FLOOR    = 1;   // floor where one car is kept parked

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic                 served_moved;
    logic                 parked_moved;
    logic [CAR_NUM_W-1:0] parked_car;
    logic [CAR_NUM_W-1:0] served_car;
  } ecd_result_t;

  function automatic logic [FLOOR_W-1:0] floor_dist(input logic [FLOOR_W-1:0] a,
                                                     input logic [FLOOR_W-1:0] b);
    logic [FLOOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

FILE: design/ecd_nearest.sv
// Picks the car nearest a target floor, optionally skipping one car.
// Depends on ecd_pkg.
module ecd_nearest #(
  parameter int CARS  = ecd_pkg::CARS_DEF,
  parameter int CAR_W = (CARS > 1) ? $clog2(CARS) : 1
) (
  input  logic [CARS-1:0][ecd_pkg::FLOOR_W-1:0] floors,
  input  logic [ecd_pkg::FLOOR_W-1:0]           target,
  input  logic                                  skip_en,
  input  logic [CAR_W-1:0]                      skip_idx,
  output logic [CAR_W-1:0]                      best_idx
);

  // Linear scan; a strictly smaller distance is needed to replace the best,
  // so equal distances keep the lower car number.
  always_comb begin
    logic                         found;
    logic [ecd_pkg::FLOOR_W-1:0]  best_d;
    logic [ecd_pkg::FLOOR_W-1:0]  d;
    found    = 1'b0;
    best_d   = '0;
    best_idx = '0;
    for (int i = 0; i < CARS; i++) begin
      d = ecd_pkg::floor_dist(floors[i], target);
      if (!(skip_en && (CAR_W'(i) == skip_idx))) begin
        if (!found || (d < best_d)) begin
          found    = 1'b1;
          best_d   = d;
          best_idx = CAR_W'(i);
        end
      end
    end
  end

endmodule

FILE: design/elevator_call_dispatcher.sv
// Top level of the elevator call dispatcher: input register, dispatch logic,
// car floor registers and result register. Depends on ecd_pkg, ecd_nearest.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[7:0] call_floor
//  out_    | out | out_tvalid/tready  | tdata: served_car, parked_car, parked_moved,
//          |     |                    |        served_moved; tuser: call_rejected
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data[7:0] top_floor
//
// A call beat is captured in the input register; when the result register
// can take it, the whole dispatch decision is made and written into the car
// floor registers and the result register at the same edge. One call is
// taken per cycle while the result side keeps accepting answers.
// The car floor update of one call is visible to the very next call, so back
// to back calls are handled without any bubble. When the result register is
// full and not taken, the input register holds and in_tready drops once it
// is occupied too. Reset (synchronous, active low) places every car at
// floor 1 and sets top_floor to 9.
module elevator_call_dispatcher #(
  parameter int CARS = ecd_pkg::CARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input beat: [7:0] call_floor.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  // Result beat: [2:0] served_car, [5:3] parked_car, [6] parked_moved,
  // [7] served_moved.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,
  // [0] call_rejected.
  output logic                          out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [ecd_pkg::FLOOR_W-1:0]   cfg_wr_data
);

  localparam int FW    = ecd_pkg::FLOOR_W;
  localparam int CNW   = ecd_pkg::CAR_NUM_W;
  localparam int CAR_W = (CARS > 1) ? $clog2(CARS) : 1;
  localparam logic [FW-1:0] PARK_F = FW'(ecd_pkg::PARK_FLOOR);

  // Configuration register.
  logic [FW-1:0] top_floor_r;

  // Input register.
  logic          s1_valid_r;
  logic [FW-1:0] s1_floor_r;

  // Car state.
  logic [CARS-1:0][FW-1:0] car_floor_r;
  logic [CARS-1:0][FW-1:0] car_floor_nxt;
  logic [CARS-1:0][FW-1:0] mid_floor;

  // Result register.
  logic                  out_valid_r;
  logic                  out_rej_r;
  ecd_pkg::ecd_result_t  out_data_r;
  ecd_pkg::ecd_result_t  res_nxt;

  logic             out_free;
  logic             s1_fire;
  logic             rej_c;
  logic             park_hit;
  logic [CAR_W-1:0] park_hit_idx;
  logic [CAR_W-1:0] near_park_idx;
  logic [CAR_W-1:0] park_idx;
  logic             srv_hit;
  logic [CAR_W-1:0] srv_hit_idx;
  logic [CAR_W-1:0] near_srv_idx;
  logic [CAR_W-1:0] srv_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign rej_c = (s1_floor_r == '0) || (s1_floor_r > top_floor_r);

  // Lowest-numbered car standing at the parking floor.
  always_comb begin
    park_hit     = 1'b0;
    park_hit_idx = '0;
    for (int i = CARS - 1; i >= 0; i--) begin
      if (car_floor_r[i] == PARK_F) begin
        park_hit     = 1'b1;
        park_hit_idx = CAR_W'(i);
      end
    end
  end

  ecd_nearest #(.CARS(CARS), .CAR_W(CAR_W)) u_near_park (
    .floors   (car_floor_r),
    .target   (PARK_F),
    .skip_en  (1'b0),
    .skip_idx ('0),
    .best_idx (near_park_idx)
  );

  assign park_idx = park_hit ? park_hit_idx : near_park_idx;

  // Car floors after the parking move.
  always_comb begin
    mid_floor = car_floor_r;
    if (!park_hit) begin
      mid_floor[park_idx] = PARK_F;
    end
  end

  // Lowest-numbered car already at the calling floor.
  always_comb begin
    srv_hit     = 1'b0;
    srv_hit_idx = '0;
    for (int i = CARS - 1; i >= 0; i--) begin
      if (mid_floor[i] == s1_floor_r) begin
        srv_hit     = 1'b1;
        srv_hit_idx = CAR_W'(i);
      end
    end
  end

  ecd_nearest #(.CARS(CARS), .CAR_W(CAR_W)) u_near_srv (
    .floors   (mid_floor),
    .target   (s1_floor_r),
    .skip_en  (1'b1),
    .skip_idx (park_idx),
    .best_idx (near_srv_idx)
  );

  assign srv_idx = srv_hit ? srv_hit_idx : near_srv_idx;

  always_comb begin
    car_floor_nxt = car_floor_r;
    res_nxt       = '0;
    if (!rej_c) begin
      car_floor_nxt          = mid_floor;
      car_floor_nxt[srv_idx] = s1_floor_r;
      res_nxt.served_car     = CNW'(srv_idx);
      res_nxt.parked_car     = CNW'(park_idx);
      res_nxt.parked_moved   = !park_hit;
      res_nxt.served_moved   = !srv_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_floor_r <= FW'(ecd_pkg::TOP_FLOOR_RST);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CARS; i++) begin
        car_floor_r[i] <= PARK_F;
      end
    end else begin
      if (cfg_wr_en) begin
        top_floor_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        car_floor_r <= car_floor_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_floor_r <= in_tdata;
    end
    if (s1_fire) begin
      out_data_r <= res_nxt;
      out_rej_r  <= rej_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rej_r;

  // The serving car ends up at the calling floor after an accepted call.
  a_served_at_floor : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !rej_c |=> car_floor_r[$past(srv_idx)] == $past(s1_floor_r))
    else $error("serving car not at calling floor");

  // Some car stands at the parking floor after an accepted call.
  a_parked_at_one : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !rej_c |=> car_floor_r[$past(park_idx)] == PARK_F ||
                          $past(s1_floor_r) == PARK_F)
    else $error("parked car not at floor 1");

  // A rejected result carries all-zero fields.
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rej_r |-> out_data_r == '0)
    else $error("rejected result with nonzero fields");

  // The input side only stalls when both registers are occupied.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for elevator_call_dispatcher: streams floor calls,
// predicts every dispatch answer and compares it beat by beat.
// Depends on ecd_pkg and the elevator_call_dispatcher RTL.
`timescale 1ns / 1ps

module tb_top;
  import ecd_pkg::*;

  localparam int CARS        = CARS_DEF;
  localparam int CYCLE_LIMIT = 600000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 100;     // long receiver hold-off
  localparam int DRAIN_WAIT  = 20;      // settle time after the last answer
  localparam int PHASES      = 8;
  localparam int PHASE_CALLS = 134;

  // One expected answer: the packed result word plus the reject flag on tuser.
  typedef struct packed {
    logic        rejected;
    ecd_result_t word;
  } call_answer_t;

  // Scoreboard: keeps its own copy of the car positions and top floor,
  // predicts the answer for every accepted call and checks answers in order.
  class dispatch_scoreboard;
    logic [FLOOR_W-1:0] top_floor;
    logic [FLOOR_W-1:0] car_floor [CARS];
    call_answer_t       pending_answers [$];
    int                 errors;

    function new();
      top_floor = FLOOR_W'(TOP_FLOOR_RST);
      foreach (car_floor[i]) car_floor[i] = FLOOR_W'(PARK_FLOOR);
      errors = 0;
    endfunction

    function void set_top(logic [FLOOR_W-1:0] value);
      top_floor = value;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    // Lowest car standing at the floor, or -1 when the floor is empty.
    function int car_at(logic [FLOOR_W-1:0] target);
      for (int i = 0; i < CARS; i++)
        if (car_floor[i] == target) return i;
      return -1;
    endfunction

    // Nearest car to the floor, skipping one car; equal distances keep the
    // lowest car number because only a strictly shorter distance replaces it.
    function int nearest_car(logic [FLOOR_W-1:0] target, int skip);
      int best;
      int best_dist;
      int d;
      best = -1;
      best_dist = 0;
      for (int i = 0; i < CARS; i++) begin
        if (i == skip) continue;
        d = (car_floor[i] > target) ? int'(car_floor[i] - target)
                                    : int'(target - car_floor[i]);
        if (best < 0 || d < best_dist) begin
          best = i;
          best_dist = d;
        end
      end
      return (best < 0) ? 0 : best;
    endfunction

    function void note_call(logic [FLOOR_W-1:0] call_floor);
      call_answer_t ans;
      int parked;
      int served;
      ans = '0;
      if (call_floor == 0 || call_floor > top_floor) begin
        // Rejected calls leave every car where it is.
        ans.rejected = 1'b1;
      end else begin
        parked = car_at(FLOOR_W'(PARK_FLOOR));
        if (parked < 0) begin
          parked = nearest_car(FLOOR_W'(PARK_FLOOR), -1);
          car_floor[parked] = FLOOR_W'(PARK_FLOOR);
          ans.word.parked_moved = 1'b1;
        end
        served = car_at(call_floor);
        if (served < 0) begin
          served = nearest_car(call_floor, parked);
          car_floor[served] = call_floor;
          ans.word.served_moved = 1'b1;
        end
        ans.word.served_car = CAR_NUM_W'(served);
        ans.word.parked_car = CAR_NUM_W'(parked);
      end
      pending_answers = {pending_answers, ans};
    endfunction

    function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
        $error("%s: expected %0d, got %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_answer(logic [7:0] tdata, logic tuser);
      call_answer_t want;
      ecd_result_t  got;
      if (pending_answers.size() == 0) begin
        $error("answer beat with no call outstanding: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      got  = ecd_result_t'(tdata);
      compare_field("served_car", want.word.served_car, got.served_car);
      compare_field("call_rejected", want.rejected, tuser);
      compare_field("parked_car", want.word.parked_car, got.parked_car);
      compare_field("parked_moved", want.word.parked_moved, got.parked_moved);
      compare_field("served_moved", want.word.served_moved, got.served_moved);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;   // [7:0] call_floor
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;  // [2:0] served_car, [5:3] parked_car,
                                  // [6] parked_moved, [7] served_moved
  logic               out_tuser;  // [0] call_rejected
  logic               cfg_wr_en;
  logic [FLOOR_W-1:0] cfg_wr_data;

  dispatch_scoreboard sb;

  // Idle controls for the call sender and the answer receiver.
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_request;
  int cycle_count;

  elevator_call_dispatcher #(
    .CARS(CARS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost answer ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Gap lengths from three ranges: mostly the shortest, sometimes the middle one, rarely the long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Mostly valid floors so that cars really move around, with some floor 0,
  // some floors above the top and some fully random bytes mixed in.
  function automatic logic [7:0] pick_floor(logic [7:0] top);
    int r;
    r = $urandom_range(0, 99);
    if (top != 0 && r < 80) return 8'($urandom_range(1, top));
    if (r < 87) return 8'd0;
    if (top != 8'hFF && r < 94) return 8'($urandom_range(top + 1, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one call beat, optionally after an idle gap, and hold it until the
  // block takes it. The beat is noted in the scoreboard at the accepting edge.
  // Valid is left high on return: the next negedge either presents the next
  // beat or lowers valid, so no beat is ever taken twice.
  task automatic send_call(logic [7:0] call_floor, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= call_floor;
    do @(posedge clk); while (!in_tready);
    sb.note_call(call_floor);
  endtask

  // Stop offering calls and wait for every outstanding answer. Each call
  // always produces an answer, so the block is idle once the queue is empty.
  task automatic drain_calls();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_top_floor(logic [7:0] value);
    drain_calls();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_top(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Answer receiver: ready is driven at the falling edge. A hold request
  // from the stimulus starts a long hold-off that is counted down here, so
  // the input side keeps pushing and the block backs up into in_tready.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left = rand_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Answer monitor: every beat accepted at a rising edge is checked in order.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_answer(out_tdata, out_tuser);
    end
  end

  // Main sequence: reset, directed calls, then randomized phases.
  initial begin
    logic [7:0] top;
    int         gap;
    sb           = new();
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset top floor of 9. A call to floor 1 is
    // served by the parked car in place. The first far call sends car 1,
    // which wins the tie with car 2. A second call to the same floor finds a
    // car there already. Floors 10, 0 and 255 are rejected.
    send_call(8'd1, 0);
    send_call(8'd9, 0);
    send_call(8'd9, 0);
    send_call(8'd5, 0);
    send_call(8'd3, 0);
    send_call(8'd10, 0);
    send_call(8'd0, 0);
    send_call(8'd255, 0);

    // Widest range: the top floor itself becomes a valid call.
    write_top_floor(8'd255);
    send_call(8'd255, 0);
    send_call(8'd254, 0);
    send_call(8'd128, 0);
    send_call(8'd1, 0);
    send_call(8'd2, 0);
    send_call(8'd127, 0);

    // Narrowest valid range: only floor 1 passes.
    write_top_floor(8'd1);
    send_call(8'd1, 0);
    send_call(8'd2, 0);
    send_call(8'd0, 0);
    send_call(8'd1, 0);

    // A top floor of zero rejects every call, floor 1 included.
    write_top_floor(8'd0);
    send_call(8'd1, 0);
    send_call(8'd0, 0);
    send_call(8'd9, 0);

    // Random phases. The first one runs with no idling on either side; the
    // others pick idle behavior at random, and two of them include a long
    // receiver hold-off while calls keep coming back to back.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       top = 8'd3;
        1:       top = 8'd255;
        2:       top = 8'd1;
        3:       top = 8'($urandom_range(4, 20));
        4:       top = 8'($urandom_range(1, 255));
        5:       top = 8'd12;
        6:       top = 8'($urandom_range(20, 254));
        default: top = 8'($urandom_range(2, 9));
      endcase
      write_top_floor(top);
      tx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_CALLS; n++) begin
        if ((ph == 3 || ph == 6) && n == PHASE_CALLS / 2) hold_request = 1'b1;
        if ((ph == 3 || ph == 6) && n >= PHASE_CALLS / 2 && n < PHASE_CALLS / 2 + 25)
          gap = 0;
        else
          gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? rand_gap() : 0;
        send_call(pick_floor(top), gap);
      end
    end

    drain_calls();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
